FILE: rtl/tcc_pkg.sv
// Shared types, constants and register codes of the text console cursor and scroll engine.
package tcc_pkg;

   localparam int WORD_W   = 14;
   localparam int REGION_W = 15;
   localparam int CHAR_W   = 8;
   localparam int SUM_W    = 16;

   localparam int unsigned SCREEN_COLS  = 80;
   localparam int unsigned SCREEN_CELLS = 80 * 25;

   localparam int unsigned DIV_SHIFT = WORD_W + 8;
   localparam int unsigned DIV_RECIP = ((1 << DIV_SHIFT) + SCREEN_COLS - 1) / SCREEN_COLS;
   localparam int RECIP_W = DIV_SHIFT + 1;
   localparam int PROD_W  = WORD_W + RECIP_W;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

   localparam logic [WORD_W-1:0]   RESET_CONSOLE_BASE = '0;
   localparam logic [REGION_W-1:0] RESET_REGION_WORDS = 15'd16000;
   localparam logic [CHAR_W-1:0]   RESET_CHAR_ATTR    = 8'd7;

   typedef enum logic {
      CMD_PUT   = 1'b0,
      CMD_PLACE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_CONSOLE_BASE = 2'd0,
      CSR_REGION_WORDS = 2'd1,
      CSR_CHAR_ATTR    = 2'd2
   } csr_index_type;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type              console_base;
      logic [REGION_W-1:0]   region_words;
      logic [CHAR_W-1:0]     char_attr;
   } cfg_type;

   typedef struct packed {
      logic                  cmd;
      logic [CHAR_W-1:0]     char_code;
      word_type              place_position;
   } req_type;

   typedef struct packed {
      logic                  write_valid;
      word_type              write_addr;
      logic [CHAR_W-1:0]     write_char;
      logic [CHAR_W-1:0]     write_attr;
      word_type              cursor_pos;
      word_type              display_start;
   } rsp_type;

endpackage

FILE: rtl/tcc_req_if.sv
// Request and result channel interfaces of the text console engine.
interface tcc_req_if;
   import tcc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [CHAR_W-1:0]    char_code;
   word_type             place_position;

   modport source (output valid, output cmd, output char_code, output place_position,
                   input ready);
   modport sink   (input valid, input cmd, input char_code, input place_position,
                   output ready);
endinterface

interface tcc_rsp_if;
   import tcc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 write_valid;
   word_type             write_addr;
   logic [CHAR_W-1:0]    write_char;
   logic [CHAR_W-1:0]    write_attr;
   word_type             cursor_pos;
   word_type             display_start;

   modport source (output valid, output write_valid, output write_addr, output write_char,
                   output write_attr, output cursor_pos, output display_start,
                   input ready);
   modport sink   (input valid, input write_valid, input write_addr, input write_char,
                   input write_attr, input cursor_pos, input display_start,
                   output ready);
endinterface

FILE: rtl/tcc_step.sv
// Next cursor, display start and cell write for one console item.
module tcc_step (
   input  tcc_pkg::cfg_type  cfg,
   input  tcc_pkg::req_type  item,
   input  tcc_pkg::word_type cursor,
   input  tcc_pkg::word_type start,
   output tcc_pkg::rsp_type  rsp
);
   import tcc_pkg::*;

   localparam logic [SUM_W-1:0] COLS_S     = SUM_W'(SCREEN_COLS);
   localparam logic [SUM_W-1:0] CELLS_S    = SUM_W'(SCREEN_CELLS);
   localparam logic [SUM_W-1:0] LAST_ROW_S = SUM_W'(SCREEN_CELLS - SCREEN_COLS);
   localparam logic [SUM_W-1:0] UP_LIM_S   = SUM_W'(SCREEN_CELLS + SCREEN_COLS);
   localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(DIV_RECIP);

   logic [SUM_W-1:0]  base_s;
   logic [SUM_W-1:0]  cur_s;
   logic [SUM_W-1:0]  start_s;
   logic [SUM_W-1:0]  top_s;
   word_type          offset;
   logic [PROD_W-1:0] prod;
   word_type          row;
   logic [SUM_W-1:0]  nl_sum;
   word_type          nl_cursor;
   word_type          bs_cursor;
   word_type          up_start;
   word_type          down_start;
   logic [SUM_W-1:0]  ns_s;

   always_comb begin
      base_s  = SUM_W'(cfg.console_base);
      cur_s   = SUM_W'(cursor);
      start_s = SUM_W'(start);
      top_s   = base_s + SUM_W'(cfg.region_words);

      offset    = (cursor >= cfg.console_base) ? cursor - cfg.console_base : '0;
      prod      = PROD_W'(offset) * PROD_W'(RECIP);
      row       = WORD_W'(prod >> DIV_SHIFT);
      nl_sum    = base_s + COLS_S * (SUM_W'(row) + SUM_W'(1));
      nl_cursor = nl_sum[WORD_W-1:0];
      bs_cursor = cursor - WORD_W'(1);

      ns_s = top_s - CELLS_S;
      if (start_s + UP_LIM_S < top_s) begin
         up_start = start + WORD_W'(SCREEN_COLS);
      end else if (SUM_W'(cfg.region_words) < CELLS_S) begin
         up_start = cfg.console_base;
      end else begin
         up_start = ns_s[WORD_W-1:0];
      end

      if (start_s < base_s + COLS_S) begin
         down_start = cfg.console_base;
      end else begin
         down_start = start - WORD_W'(SCREEN_COLS);
      end

      rsp.write_valid   = 1'b0;
      rsp.write_addr    = '0;
      rsp.write_char    = '0;
      rsp.write_attr    = '0;
      rsp.cursor_pos    = cursor;
      rsp.display_start = start;

      if (item.cmd == CMD_PLACE) begin
         rsp.cursor_pos    = item.place_position;
         rsp.display_start = cfg.console_base;
      end else if (item.char_code == CH_NEWLINE) begin
         if (cur_s + COLS_S < top_s) begin
            rsp.cursor_pos = nl_cursor;
            if (SUM_W'(nl_cursor) == start_s + LAST_ROW_S) begin
               rsp.display_start = up_start;
            end
         end
      end else if (item.char_code == CH_BACKSPACE) begin
         if (cursor > cfg.console_base) begin
            rsp.cursor_pos  = bs_cursor;
            rsp.write_valid = 1'b1;
            rsp.write_addr  = bs_cursor;
            rsp.write_char  = CH_BLANK;
            rsp.write_attr  = cfg.char_attr;
            if (bs_cursor == start) begin
               rsp.display_start = down_start;
            end
         end
      end else begin
         if (cur_s + SUM_W'(1) < top_s) begin
            if (cur_s == start_s + LAST_ROW_S) begin
               rsp.display_start = up_start;
            end
            rsp.write_valid = 1'b1;
            rsp.write_addr  = cursor;
            rsp.write_char  = item.char_code;
            rsp.write_attr  = cfg.char_attr;
            rsp.cursor_pos  = cursor + WORD_W'(1);
         end
      end
   end

endmodule

FILE: rtl/text_console_cursor_scroll.sv
// Top level of the text console cursor and scroll engine.
// Takes one item per cycle unless the result side stalls: a character to put (newline,
// backspace or printable) or a cursor placement. Each item gives exactly one result, via
// the input register and then the result register: an optional video cell write plus
// the new cursor position and display start. The cursor and start update as the item
// moves from the input register to the result register, so items follow each other in
// consecutive cycles with no gap; a stalled result holds the input side only once both
// registers are full. Write csr registers only while no item is in flight.
module text_console_cursor_scroll (
   input  logic                           clock,
   input  logic                           reset,
   tcc_req_if.sink                        req_chan,
   tcc_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [tcc_pkg::REGION_W-1:0]   csr_wdata
);
   import tcc_pkg::*;

   cfg_type  cfg_ff,       cfg_in;
   logic     in_valid_ff,  in_valid_in;
   req_type  in_item_ff,   in_item_in;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_ff,       out_in;
   word_type cursor_ff,    cursor_in;
   word_type start_ff,     start_in;
   rsp_type  step_rsp;
   logic     advance;
   logic     take;

   tcc_step u_step (
      .cfg    (cfg_ff),
      .item   (in_item_ff),
      .cursor (cursor_ff),
      .start  (start_ff),
      .rsp    (step_rsp)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.write_valid   = out_ff.write_valid;
   assign rsp_chan.write_addr    = out_ff.write_addr;
   assign rsp_chan.write_char    = out_ff.write_char;
   assign rsp_chan.write_attr    = out_ff.write_attr;
   assign rsp_chan.cursor_pos    = out_ff.cursor_pos;
   assign rsp_chan.display_start = out_ff.display_start;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CONSOLE_BASE: cfg_in.console_base = csr_wdata[WORD_W-1:0];
            CSR_REGION_WORDS: cfg_in.region_words = csr_wdata;
            CSR_CHAR_ATTR:    cfg_in.char_attr    = csr_wdata[CHAR_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end

      in_valid_in = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in  = in_item_ff;
      if (take) begin
         in_item_in.cmd            = req_chan.cmd;
         in_item_in.char_code      = req_chan.char_code;
         in_item_in.place_position = req_chan.place_position;
      end

      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      out_in       = advance ? step_rsp : out_ff;
      cursor_in    = advance ? step_rsp.cursor_pos : cursor_ff;
      start_in     = advance ? step_rsp.display_start : start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.console_base <= RESET_CONSOLE_BASE;
         cfg_ff.region_words <= RESET_REGION_WORDS;
         cfg_ff.char_attr    <= RESET_CHAR_ATTR;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         cursor_ff           <= '0;
         start_ff            <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cursor_ff    <= cursor_in;
         start_ff     <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_ff     <= out_in;
   end

endmodule
